// ===== hdl/twmc_pkg.sv =====
// shared types and constants of the two-window max coverage unit
`default_nettype none

package twmc_pkg;

  localparam int POS_W          = 30;
  localparam int CNT_W          = 11;
  localparam int STATUS_W       = 2;
  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]    best_two;
    logic [CNT_W-1:0]    window_count;
    logic [STATUS_W-1:0] status;
    logic                set_done;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/two_window_max_coverage_unit.sv =====
// top level of the two-window max coverage unit: window scan sequencer and point stores
`default_nettype none

// channel   | ports                          | transfers
// ----------+--------------------------------+------------------------------------------
// input     | in_valid, in_ready, in_data    | one point position and its last flag
// result    | out_valid, out_ready, out_data | best_two, window_count, status, set_done
// config    | cfg_we, cfg_wdata              | window span, written without handshake
//
// an accepted transaction passes an accept step, then one scan step per compare against the
// single read port of the position store, the window start advancing on every compare but
// the last, then an emit step that finishes the sum and emits the result
// since the start only moves forward, its advances average at most one per point over a set
// ignored items (store full, out of order) go from the accept step straight to emit
// synchronous active-low reset clears the set state; the stores need no clearing
// a waiting result is held in the output register while the next item is accepted;
// a new result waits in the emit step until the output register is free

module two_window_max_coverage_unit
  import twmc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_wdata
);

  // index width for the stores, count width that can hold MAX_POINTS itself
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    EMIT
  } state_t;

  state_t               state_r;
  logic [POS_W-1:0]     span_r;
  logic [POS_W-1:0]     pos_r;
  logic                 last_r;
  logic                 ok_r;
  logic [STATUS_W-1:0]  status_r;
  logic [CW-1:0]        head_r;
  logic [CW-1:0]        start_r;
  logic [CW-1:0]        best_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        last_prefix_r;
  logic [POS_W-1:0]     prev_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // point stores, contents undefined until written
  logic [POS_W-1:0]     pos_mem [MAX_POINTS];
  logic [CW-1:0]        prefix_mem [MAX_POINTS];
  logic [POS_W-1:0]     pos_rdata_r;
  logic [CW-1:0]        pre_rdata_r;

  logic                 in_fire;
  logic                 is_full;
  logic                 is_order;
  logic                 scan_adv;
  logic                 out_free;
  logic [CW-1:0]        start_inc;
  logic [IW-1:0]        pos_rd_addr;
  logic [IW-1:0]        pre_rd_addr;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        prefix_wdata;
  logic                 prefix_we;
  logic [CW-1:0]        earlier_best;
  logic [CW:0]          total;
  logic [CW-1:0]        best_nxt;

  // count to output field width, zero extended or truncated as the depth demands
  function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
    logic [CW+CNT_W-1:0] ext;
    ext = {{CNT_W{1'b0}}, v};
    return ext[CNT_W-1:0];
  endfunction

  assign in_ready  = (state_r == IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    is_full   = (head_r == CW'(MAX_POINTS));
    is_order  = (in_data.position < prev_r);
    start_inc = start_r + 1'b1;
    // oldest point falls out of the window when it lies more than span below the new one
    scan_adv  = (start_r < head_r) &&
                (({1'b0, pos_rdata_r} + {1'b0, span_r}) < {1'b0, pos_r});
    pos_rd_addr = (state_r == SCAN && scan_adv) ? start_inc[IW-1:0] : start_r[IW-1:0];
    pre_rd_addr = start_r[IW-1:0] - 1'b1;
    count_nxt    = head_r - start_r + 1'b1;
    prefix_wdata = (count_nxt > last_prefix_r) ? count_nxt : last_prefix_r;
    prefix_we    = (state_r == SCAN) && !scan_adv;
    // best window ending before the start, none when the window starts at the first point or the item is ignored
    earlier_best = (ok_r && start_r != '0) ? pre_rdata_r : '0;
    total    = {1'b0, count_r} + {1'b0, earlier_best};
    best_nxt = (total > {1'b0, best_r}) ? total[CW-1:0] : best_r;
  end

  // position store: written when an in-order point is accepted with room left, read every cycle at the window start
  always_ff @(posedge clk) begin
    if (in_fire && !is_full && !is_order) begin
      pos_mem[head_r[IW-1:0]] <= in_data.position;
    end
    pos_rdata_r <= pos_mem[pos_rd_addr];
  end

  // prefix best store: written when the scan settles, read just before the window start
  always_ff @(posedge clk) begin
    if (prefix_we) begin
      prefix_mem[head_r[IW-1:0]] <= prefix_wdata;
    end
    pre_rdata_r <= prefix_mem[pre_rd_addr];
  end

  // sequencer, set state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= IDLE;
      span_r        <= '0;
      head_r        <= '0;
      start_r       <= '0;
      best_r        <= '0;
      last_prefix_r <= '0;
      prev_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        span_r <= cfg_wdata;
      end
      // output register loads in the emit step, empties when the receiver takes it
      if (state_r == EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            pos_r   <= in_data.position;
            last_r  <= in_data.last;
            count_r <= '0;
            priority if (is_full) begin
              ok_r     <= 1'b0;
              status_r <= STATUS_FULL;
              state_r  <= EMIT;
            end else if (is_order) begin
              ok_r     <= 1'b0;
              status_r <= STATUS_ORDER;
              state_r  <= EMIT;
            end else begin
              ok_r     <= 1'b1;
              status_r <= STATUS_OK;
              state_r  <= SCAN;
            end
          end
        end
        SCAN: begin
          if (scan_adv) begin
            start_r <= start_inc;
          end else begin
            count_r       <= count_nxt;
            last_prefix_r <= prefix_wdata;
            state_r       <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            out_data_r.best_two     <= to_cnt(best_nxt);
            out_data_r.window_count <= to_cnt(count_r);
            out_data_r.status       <= status_r;
            out_data_r.set_done     <= last_r;
            // end of set clears everything but the span
            if (last_r) begin
              head_r        <= '0;
              start_r       <= '0;
              best_r        <= '0;
              last_prefix_r <= '0;
              prev_r        <= '0;
            end else begin
              best_r <= best_nxt;
              if (ok_r) begin
                head_r <= head_r + 1'b1;
                prev_r <= pos_r;
              end
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  // no second transaction while one is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted twice in a row");

  // window start never passes the newest stored point
  a_start_le_head: assert property (@(posedge clk) disable iff (!rst_n)
    start_r <= head_r)
    else $error("window start beyond head");

  // two disjoint windows never cover more points than are stored
  a_best_le_head: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= head_r)
    else $error("best coverage exceeds stored points");

  // a result only appears out of the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == EMIT))
    else $error("result raised outside emit");

endmodule

`default_nettype wire
